FILE: hdl/gmw_pkg.sv
// shared constants, register indexes and element lookup for the greyscale morphology window
package gmw_pkg;

    localparam int MAX_LINE_DEF    = 1024;
    localparam int MAX_ELEMENT_DEF = 3;
    localparam int PIXEL_BITS_DEF  = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int SIZE_W      = 11;
    localparam int EXTENT_W    = 2;
    localparam int EXT_W       = 3;
    localparam int ELEM_W      = 8;
    localparam int ELEM_ROWS   = 3;
    localparam int ELEM_COLS   = 3;
    localparam int RESULT_W    = 10;
    localparam int RESULT_BYTES_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0]   LINE_LENGTH_RST = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0]   LINE_COUNT_RST  = SIZE_W'(1024);
    localparam logic [EXTENT_W-1:0] EXTENT_RST      = EXTENT_W'(3);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_LINE_LENGTH = 3'd1,
        CFG_LINE_COUNT  = 3'd2,
        CFG_ELEM_ROWS   = 3'd3,
        CFG_ELEM_COLS   = 3'd4,
        CFG_ELEM_ROW_A  = 3'd5,
        CFG_ELEM_ROW_B  = 3'd6,
        CFG_ELEM_ROW_C  = 3'd7
    } t_cfg_index;

    typedef logic [ELEM_ROWS-1:0][CFG_DATA_W-1:0] t_elem_rows;

    // signed element entry, zero outside the stored rows and columns
    function automatic logic signed [ELEM_W-1:0] elem_entry(
        input t_elem_rows    rows,
        input logic [EXT_W-1:0] i,
        input logic [EXT_W-1:0] j
    );
        logic signed [ELEM_W-1:0] v;
        v = '0;
        if (i < EXT_W'(ELEM_ROWS) && j < EXT_W'(ELEM_COLS)) begin
            v = $signed(rows[i[1:0]][j[1:0]*ELEM_W +: ELEM_W]);
        end
        return v;
    endfunction

endpackage

FILE: hdl/greyscale_morphology_window.sv
// top level: line buffers, 3 by 3 window and non-flat erosion or dilation
// an input goes through the stage 1 registers and the window into the output register
// throughput: one pixel per cycle unless stalled; each line buffer: one read, one write a cycle
// a result appears only for pixels that complete a full element-sized window
// reset clears configuration, valid flags, positions and window; line buffers are not cleared
// reset loads mode erosion, 1024 by 1024 frame, 3 by 3 zero element
module greyscale_morphology_window #(
    parameter int MAX_LINE    = gmw_pkg::MAX_LINE_DEF,
    parameter int MAX_ELEMENT = gmw_pkg::MAX_ELEMENT_DEF,
    parameter int PIXEL_BITS  = gmw_pkg::PIXEL_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [gmw_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [gmw_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]        s_axis_tdata,  // pixel
    input  logic                                   s_axis_tuser,  // frame_start
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [(((PIXEL_BITS > gmw_pkg::ELEM_W ? PIXEL_BITS : gmw_pkg::ELEM_W)
                    + 9) / 8) * 8 - 1:0]           m_axis_tdata,  // result_value
    output logic                                   m_axis_tlast   // frame_end
);

    localparam int AW  = $clog2(MAX_LINE);
    localparam int LW  = ($clog2(MAX_LINE + 1) > gmw_pkg::SIZE_W) ?
                         $clog2(MAX_LINE + 1) : gmw_pkg::SIZE_W;
    localparam int EW  = gmw_pkg::EXT_W;
    localparam int VW  = ((PIXEL_BITS > gmw_pkg::ELEM_W) ? PIXEL_BITS : gmw_pkg::ELEM_W) + 2;
    localparam int OW  = ((VW + 7) / 8) * 8;
    localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

    // configuration registers
    logic                                r_mode;
    logic [gmw_pkg::SIZE_W-1:0]          r_line_length;
    logic [gmw_pkg::SIZE_W-1:0]          r_line_count;
    logic [gmw_pkg::EXTENT_W-1:0]        r_elem_rows;
    logic [gmw_pkg::EXTENT_W-1:0]        r_elem_cols;
    gmw_pkg::t_elem_rows                 r_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_line_length <= gmw_pkg::LINE_LENGTH_RST;
            r_line_count  <= gmw_pkg::LINE_COUNT_RST;
            r_elem_rows   <= gmw_pkg::EXTENT_RST;
            r_elem_cols   <= gmw_pkg::EXTENT_RST;
            r_elem        <= '0;
        end else if (i_cfg_wr_en) begin
            case (gmw_pkg::t_cfg_index'(i_cfg_index))
                gmw_pkg::CFG_MODE:        r_mode        <= i_cfg_data[0];
                gmw_pkg::CFG_LINE_LENGTH: r_line_length <= i_cfg_data[gmw_pkg::SIZE_W-1:0];
                gmw_pkg::CFG_LINE_COUNT:  r_line_count  <= i_cfg_data[gmw_pkg::SIZE_W-1:0];
                gmw_pkg::CFG_ELEM_ROWS:   r_elem_rows   <= i_cfg_data[gmw_pkg::EXTENT_W-1:0];
                gmw_pkg::CFG_ELEM_COLS:   r_elem_cols   <= i_cfg_data[gmw_pkg::EXTENT_W-1:0];
                gmw_pkg::CFG_ELEM_ROW_A:  r_elem[0]     <= i_cfg_data;
                gmw_pkg::CFG_ELEM_ROW_B:  r_elem[1]     <= i_cfg_data;
                gmw_pkg::CFG_ELEM_ROW_C:  r_elem[2]     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped sizes and extents
    logic [LW-1:0] w_len, w_cnt, w_len_x, w_cnt_x;
    logic [EW-1:0] w_er, w_ec, w_er_x, w_ec_x;

    always_comb begin
        w_len_x = LW'(r_line_length);
        w_cnt_x = LW'(r_line_count);
        w_er_x  = EW'(r_elem_rows);
        w_ec_x  = EW'(r_elem_cols);
        w_len = w_len_x;
        if (w_len_x == '0) w_len = LW'(1);
        else if (w_len_x > LW'(MAX_LINE)) w_len = LW'(MAX_LINE);
        w_cnt = w_cnt_x;
        if (w_cnt_x == '0) w_cnt = LW'(1);
        else if (w_cnt_x > LW'(MAX_LINE)) w_cnt = LW'(MAX_LINE);
        w_er = w_er_x;
        if (w_er_x == '0) w_er = EW'(1);
        else if (w_er_x > EW'(MAX_ELEMENT)) w_er = EW'(MAX_ELEMENT);
        w_ec = w_ec_x;
        if (w_ec_x == '0) w_ec = EW'(1);
        else if (w_ec_x > EW'(MAX_ELEMENT)) w_ec = EW'(MAX_ELEMENT);
    end

    // pipeline flow control
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic w_out_free, w_s2_free, w_s1_free, w_s1_go, w_in_go;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_s2_free     = !r_s2_valid || w_out_free;
    assign w_s1_free     = !r_s1_valid || w_s2_free;
    assign w_s1_go       = r_s1_valid && w_s2_free;
    assign w_in_go       = s_axis_tvalid && w_s1_free;
    assign s_axis_tready = w_s1_free;

    // raster position
    logic [AW-1:0] r_col_pos, r_row_pos, n_col_pos, n_row_pos;
    logic [AW-1:0] w_c, w_r;
    logic [LW-1:0] w_c1, w_r1;
    logic          w_restart, w_emit, w_last;

    always_comb begin
        w_restart = s_axis_tuser || (LW'(r_col_pos) >= w_len) || (LW'(r_row_pos) >= w_cnt);
        w_c  = w_restart ? '0 : r_col_pos;
        w_r  = w_restart ? '0 : r_row_pos;
        w_c1 = LW'(w_c) + LW'(1);
        w_r1 = LW'(w_r) + LW'(1);
        w_emit = (w_r1 >= LW'(w_er)) && (w_c1 >= LW'(w_ec));
        w_last = (w_r1 == w_cnt) && (w_c1 == w_len);
        if (w_c1 >= w_len) begin
            n_col_pos = '0;
            n_row_pos = (w_r1 >= w_cnt) ? '0 : w_r1[AW-1:0];
        end else begin
            n_col_pos = w_c1[AW-1:0];
            n_row_pos = w_r;
        end
    end

    // stage 1: line buffer read data and pixel
    logic [PIXEL_BITS-1:0] r_s1_pixel;
    logic [AW-1:0]         r_s1_addr;
    logic                  r_s1_emit, r_s1_last, r_fwd_hit;
    logic [PIXEL_BITS-1:0] w_col [MAX_ELEMENT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (w_in_go) begin
                r_col_pos <= n_col_pos;
                r_row_pos <= n_row_pos;
                r_fwd_hit <= w_s1_go && (r_s1_addr == w_c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_go) begin
            r_s1_pixel <= s_axis_tdata[PIXEL_BITS-1:0];
            r_s1_addr  <= w_c;
            r_s1_emit  <= w_emit;
            r_s1_last  <= w_last;
        end
    end

    assign w_col[0] = r_s1_pixel;

    // line buffer k holds column entry k-1 of earlier transfers; read at accept, write in stage 1
    for (genvar k = 1; k < MAX_ELEMENT; k++) begin : g_line
        logic [PIXEL_BITS-1:0] r_mem [MAX_LINE];
        logic [PIXEL_BITS-1:0] r_rd;
        logic [PIXEL_BITS-1:0] r_fwd;

        always_ff @(posedge i_clk) begin
            if (w_s1_go) begin
                r_mem[r_s1_addr] <= w_col[k-1];
            end
            if (w_in_go) begin
                r_rd  <= r_mem[w_c];
                r_fwd <= w_col[k-1];
            end
        end

        // same address written and read at one edge: take the written pixel
        assign w_col[k] = r_fwd_hit ? r_fwd : r_rd;
    end

    // window, updated as stage 1 moves on
    logic [PIXEL_BITS-1:0] r_win [MAX_ELEMENT][MAX_ELEMENT];
    logic                  r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < MAX_ELEMENT; a++) begin
                for (int b = 0; b < MAX_ELEMENT; b++) begin
                    r_win[a][b] <= '0;
                end
            end
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_go) begin
                for (int a = 0; a < MAX_ELEMENT; a++) begin
                    for (int b = MAX_ELEMENT - 1; b > 0; b--) begin
                        r_win[a][b] <= r_win[a][b-1];
                    end
                    r_win[a][0] <= w_col[a];
                end
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid && r_s1_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_free) begin
            r_s2_last <= r_s1_last;
        end
    end

    // stage 2: per-tap sums (dilation) or differences (erosion), row reduction, then across rows
    logic signed [VW-1:0] w_row_best [MAX_ELEMENT];
    logic signed [VW-1:0] w_best;

    always_comb begin
        logic signed [VW-1:0]             pv, ev, cand;
        logic signed [gmw_pkg::ELEM_W-1:0] e;
        logic [EW-1:0]                    ia, jb;
        for (int a = 0; a < MAX_ELEMENT; a++) begin
            w_row_best[a] = r_mode ? V_MIN : V_MAX;
            for (int b = 0; b < MAX_ELEMENT; b++) begin
                if (r_mode) begin
                    ia = EW'(a);
                    jb = EW'(b);
                end else begin
                    ia = w_er - EW'(1) - EW'(a);
                    jb = w_ec - EW'(1) - EW'(b);
                end
                e  = gmw_pkg::elem_entry(r_elem, ia, jb);
                pv = VW'(r_win[a][b]);
                ev = VW'(e);
                if (EW'(a) >= w_er || EW'(b) >= w_ec) begin
                    cand = r_mode ? V_MIN : V_MAX;
                end else if (r_mode) begin
                    cand = pv + ev;
                end else begin
                    cand = pv - ev;
                end
                if (r_mode ? (cand > w_row_best[a]) : (cand < w_row_best[a])) begin
                    w_row_best[a] = cand;
                end
            end
        end
        w_best = w_row_best[0];
        for (int a = 1; a < MAX_ELEMENT; a++) begin
            if (r_mode ? (w_row_best[a] > w_best) : (w_row_best[a] < w_best)) begin
                w_best = w_row_best[a];
            end
        end
    end

    // output register
    logic [VW-1:0] r_out_value;
    logic          r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_value <= w_best;
            r_out_last  <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OW'(r_out_value);
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_ready_when_out_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    a_frame_start_origin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (r_s1_addr == '0))
        else $error("frame start transfer not placed at column zero");

    a_s2_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !w_out_free) |=> (r_s2_valid && $stable(r_s2_last)))
        else $error("stage 2 result lost while output stalled");

    a_fwd_needs_stage1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_go && w_s1_go && (r_s1_addr == w_c)) |=> r_fwd_hit)
        else $error("line buffer bypass missed");
`endif

endmodule

FILE: dv/greyscale_morphology_window_tb.sv
// testbench for greyscale_morphology_window: directed and random frames checked against a local model
module greyscale_morphology_window_tb;

    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic signed [gmw_pkg::RESULT_W-1:0] value;
        logic                                frame_end;
    } t_morph_result;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_wr_en;
    logic [gmw_pkg::CFG_INDEX_W-1:0]    i_cfg_index;
    logic [gmw_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [7:0]                         s_axis_tdata;   // pixel
    logic                               s_axis_tuser;   // frame_start
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [gmw_pkg::RESULT_BYTES_W-1:0] m_axis_tdata;   // result_value
    logic                               m_axis_tlast;   // frame_end

    greyscale_morphology_window dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // model state and configuration
    logic                       cfg_mode;
    logic [gmw_pkg::SIZE_W-1:0] cfg_len;
    logic [gmw_pkg::SIZE_W-1:0] cfg_cnt;
    logic [1:0]                 cfg_rows;
    logic [1:0]                 cfg_cols;
    logic [23:0]                cfg_elem [3];
    logic [7:0]                 line_mem [2][1024];
    logic [7:0]                 win [3][3];
    int                         col_pos;
    int                         row_pos;

    t_morph_result expected_results[$];
    t_morph_result exp_item;

    int  mismatches      = 0;
    int  pixels_sent     = 0;
    int  results_checked = 0;
    int  configs_applied = 0;
    int  stall_cycles    = 0;
    bit  quiet_mode      = 1'b0;
    bit  hold_off_req    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int effective_size(input logic [gmw_pkg::SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > 1024) return 1024;
        return int'(v);
    endfunction

    function automatic int effective_extent(input logic [1:0] v);
        if (v == 0) return 1;
        return int'(v);
    endfunction

    function automatic int elem_weight(input int i, input int j);
        return int'($signed(cfg_elem[i][8*j +: 8]));
    endfunction

    function automatic int pick_gap();
        int roll;
        if (quiet_mode) return 0;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] rand_element();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) return 24'h808080;
        if (roll < 30) return 24'h7F7F7F;
        return 24'($urandom());
    endfunction

    function automatic logic [7:0] rand_pixel();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return 8'($urandom());
    endfunction

    task automatic morph_reset();
        cfg_mode = 1'b0;
        cfg_len  = gmw_pkg::LINE_LENGTH_RST;
        cfg_cnt  = gmw_pkg::LINE_COUNT_RST;
        cfg_rows = gmw_pkg::EXTENT_RST;
        cfg_cols = gmw_pkg::EXTENT_RST;
        col_pos  = 0;
        row_pos  = 0;
        for (int k = 0; k < 3; k++) begin
            cfg_elem[k] = '0;
            for (int j = 0; j < 3; j++) win[k][j] = '0;
        end
        for (int k = 0; k < 2; k++)
            for (int c = 0; c < 1024; c++) line_mem[k][c] = '0;
    endtask

    task automatic morph_step(input logic [7:0] px, input logic fs,
                              output logic produced, output t_morph_result res);
        int len, cnt, ext_r, ext_c, c, r, best, v, p;
        logic [7:0] column [3];
        len   = effective_size(cfg_len);
        cnt   = effective_size(cfg_cnt);
        ext_r = effective_extent(cfg_rows);
        ext_c = effective_extent(cfg_cols);
        produced      = 1'b0;
        res.value     = '0;
        res.frame_end = 1'b0;
        if (fs || col_pos >= len || row_pos >= cnt) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        column[0] = px;
        column[1] = line_mem[0][c];
        column[2] = line_mem[1][c];
        line_mem[1][c] = column[1];
        line_mem[0][c] = column[0];
        for (int k = 0; k < 3; k++) begin
            win[k][2] = win[k][1];
            win[k][1] = win[k][0];
            win[k][0] = column[k];
        end
        if (r + 1 >= ext_r && c + 1 >= ext_c) begin
            best = cfg_mode ? -100000 : 100000;
            for (int i = 0; i < ext_r; i++) begin
                for (int j = 0; j < ext_c; j++) begin
                    p = int'(win[ext_r-1-i][ext_c-1-j]);
                    if (cfg_mode) begin
                        v = p + elem_weight(ext_r-1-i, ext_c-1-j);
                        if (v > best) best = v;
                    end else begin
                        v = p - elem_weight(i, j);
                        if (v < best) best = v;
                    end
                end
            end
            res.value     = best[gmw_pkg::RESULT_W-1:0];
            res.frame_end = (r + 1 == cnt) && (c + 1 == len);
            produced      = 1'b1;
        end
        c++;
        if (c >= len) begin
            c = 0;
            r++;
            if (r >= cnt) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic write_reg(input gmw_pkg::t_cfg_index idx,
                             input logic [gmw_pkg::CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            gmw_pkg::CFG_MODE:        cfg_mode    = val[0];
            gmw_pkg::CFG_LINE_LENGTH: cfg_len     = val[gmw_pkg::SIZE_W-1:0];
            gmw_pkg::CFG_LINE_COUNT:  cfg_cnt     = val[gmw_pkg::SIZE_W-1:0];
            gmw_pkg::CFG_ELEM_ROWS:   cfg_rows    = val[1:0];
            gmw_pkg::CFG_ELEM_COLS:   cfg_cols    = val[1:0];
            gmw_pkg::CFG_ELEM_ROW_A:  cfg_elem[0] = val;
            gmw_pkg::CFG_ELEM_ROW_B:  cfg_elem[1] = val;
            gmw_pkg::CFG_ELEM_ROW_C:  cfg_elem[2] = val;
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic m, input logic [gmw_pkg::SIZE_W-1:0] len,
                             input logic [gmw_pkg::SIZE_W-1:0] cnt, input logic [1:0] rows,
                             input logic [1:0] cols, input logic [23:0] elem_a,
                             input logic [23:0] elem_b, input logic [23:0] elem_c);
        write_reg(gmw_pkg::CFG_MODE, gmw_pkg::CFG_DATA_W'(m));
        write_reg(gmw_pkg::CFG_LINE_LENGTH, gmw_pkg::CFG_DATA_W'(len));
        write_reg(gmw_pkg::CFG_LINE_COUNT, gmw_pkg::CFG_DATA_W'(cnt));
        write_reg(gmw_pkg::CFG_ELEM_ROWS, gmw_pkg::CFG_DATA_W'(rows));
        write_reg(gmw_pkg::CFG_ELEM_COLS, gmw_pkg::CFG_DATA_W'(cols));
        write_reg(gmw_pkg::CFG_ELEM_ROW_A, elem_a);
        write_reg(gmw_pkg::CFG_ELEM_ROW_B, elem_b);
        write_reg(gmw_pkg::CFG_ELEM_ROW_C, elem_c);
        configs_applied++;
    endtask

    task automatic send_pixel(input logic [7:0] px, input logic fs);
        int            gap;
        logic          got;
        t_morph_result res;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= fs;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        morph_step(px, fs, got, res);
        if (got) expected_results.push_back(res);
        pixels_sent++;
    endtask

    // stop offering, wait for every pending result, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
    endtask

    // output transfer check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result value %0d last %0b",
                              $signed(m_axis_tdata[gmw_pkg::RESULT_W-1:0]), m_axis_tlast));
            end else begin
                exp_item = expected_results.pop_front();
                if (m_axis_tdata[gmw_pkg::RESULT_W-1:0] !== exp_item.value ||
                    m_axis_tlast !== exp_item.frame_end)
                    note_mismatch($sformatf("expected value %0d last %0b, got value %0d last %0b",
                                  exp_item.value, exp_item.frame_end,
                                  $signed(m_axis_tdata[gmw_pkg::RESULT_W-1:0]), m_axis_tlast));
            end
        end
    end

    // receiver with random stalls and a long hold-off on request
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (stall - 1) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results pending",
                 stall_cycles, expected_results.size());
        $display("Verification failed");
        $finish;
    end

    task automatic test_erosion_window();
        logic [7:0] pix [9] = '{8'd0, 8'd255, 8'd17, 8'd255, 8'd0, 8'd128, 8'd200, 8'd1, 8'd255};
        configure(1'b0, 11'd3, 11'd3, 2'd3, 2'd3, 24'h7F8001, 24'h80007F, 24'h017F80);
        for (int n = 0; n < 9; n++) send_pixel(pix[n], n == 0);
        settle();
    endtask

    // zero extents act as one; frame of two wraps without frame_start
    task automatic test_dilation_extremes();
        configure(1'b1, 11'd2, 11'd1, 2'd0, 2'd0, 24'h000080, rand_element(), rand_element());
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        settle();
        write_reg(gmw_pkg::CFG_ELEM_ROW_A, 24'h00007F);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        settle();
    endtask

    task automatic test_zero_sizes();
        configure(1'b0, 11'd0, 11'd0, 2'd1, 2'd1, rand_element(), rand_element(), rand_element());
        for (int n = 0; n < 3; n++) send_pixel(rand_pixel(), n == 0);
        settle();
    endtask

    task automatic test_undersized_frame();
        configure(1'b1, 11'd2, 11'd2, 2'd3, 2'd3, rand_element(), rand_element(), rand_element());
        for (int n = 0; n < 4; n++) send_pixel(rand_pixel(), n == 0);
        settle();
    endtask

    // shrink the frame mid-way so the stored row falls outside it
    task automatic test_position_reset();
        configure(1'b0, 11'd3, 11'd3, 2'd1, 2'd1, rand_element(), rand_element(), rand_element());
        for (int n = 0; n < 5; n++) send_pixel(rand_pixel(), n == 0);
        settle();
        write_reg(gmw_pkg::CFG_LINE_COUNT, gmw_pkg::CFG_DATA_W'(1));
        for (int n = 0; n < 3; n++) send_pixel(rand_pixel(), 1'b0);
        settle();
    endtask

    task automatic test_random_frames();
        int         start_pixels, start_results, frames, stop_at, len, cnt, roll;
        logic [10:0] len_val;
        logic       fs;
        start_pixels  = pixels_sent;
        start_results = results_checked;
        while (pixels_sent - start_pixels < 500 || results_checked - start_results < 48) begin
            quiet_mode = ($urandom_range(3) == 0);
            roll = $urandom_range(19);
            if (roll == 0)      len_val = 11'd0;
            else if (roll == 1) len_val = 11'd1;
            else if (roll == 2) len_val = 11'($urandom_range(11, 40));
            else                len_val = 11'($urandom_range(2, 10));
            configure(1'($urandom_range(1)), len_val, 11'($urandom_range(0, 7)),
                      2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      rand_element(), rand_element(), rand_element());
            len    = effective_size(cfg_len);
            cnt    = effective_size(cfg_cnt);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                stop_at = len * cnt;
                if ($urandom_range(9) == 0) stop_at = $urandom_range(1, len * cnt);
                for (int n = 0; n < stop_at; n++) begin
                    fs = (n == 0) && (f == 0 || $urandom_range(1) == 1);
                    if ($urandom_range(59) == 0) fs = 1'b1;
                    send_pixel(rand_pixel(), fs);
                end
            end
            settle();
        end
        quiet_mode = 1'b0;
    endtask

    // oversized line length acts as the maximum; the line wraps at 1024
    task automatic test_long_lines();
        configure(1'($urandom_range(1)), 11'h7FF, 11'd1, 2'd1, 2'd3,
                  rand_element(), rand_element(), rand_element());
        for (int n = 0; n < 1030; n++) send_pixel(rand_pixel(), n == 0);
        settle();
    endtask

    task automatic test_tall_frame();
        configure(1'($urandom_range(1)), 11'd1, 11'd1024, 2'd3, 2'd1,
                  rand_element(), rand_element(), rand_element());
        for (int n = 0; n < 200; n++) send_pixel(rand_pixel(), n == 0);
        settle();
    endtask

    task automatic test_backpressure();
        configure(1'b0, 11'd4, 11'd4, 2'd1, 2'd1, rand_element(), rand_element(), rand_element());
        hold_off_req = 1'b1;
        for (int n = 0; n < 80; n++) send_pixel(rand_pixel(), n == 0);
        settle();
        quiet_mode = 1'b1;
        for (int n = 0; n < 40; n++) send_pixel(rand_pixel(), 1'b0);
        settle();
        quiet_mode = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= gmw_pkg::CFG_MODE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        morph_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_erosion_window();
        test_dilation_extremes();
        test_zero_sizes();
        test_undersized_frame();
        test_position_reset();
        test_backpressure();
        test_long_lines();
        test_tall_frame();
        test_random_frames();

        $display("run covered %0d pixels and %0d results over %0d register settings,",
                 pixels_sent, results_checked, configs_applied);
        $display("erosion and dilation, extents 0 to 3, frames from 1x1 up to 1024 long");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
